/* rtl/rpoc_pkg.sv */
`timescale 1ns / 1ps
package rpoc_pkg;

  localparam int unsigned VAL_W   = 10;
  localparam int unsigned PULSE_W = 16;
  localparam int unsigned SVAL_W  = 17;
  localparam int unsigned BIN_W   = 4;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [VAL_W-1:0]         val_t;
  typedef logic signed [SVAL_W-1:0] sval_t;
  typedef logic [BIN_W-1:0]         bin_t;
  typedef logic [MODE_W-1:0]        mode_t;
  typedef logic [CMD_W-1:0]         cmd_t;

  localparam mode_t MODE_USER  = 2'd0;
  localparam mode_t MODE_ANGLE = 2'd1;
  localparam mode_t MODE_PILOT = 2'd2;
  localparam mode_t MODE_OTHER = 2'd3;

  localparam cmd_t ST_IDLE    = 3'd0;
  localparam cmd_t ST_ECHO    = 3'd1;
  localparam cmd_t ST_MODE    = 3'd2;
  localparam cmd_t ST_READ    = 3'd3;
  localparam cmd_t ST_WRITE   = 3'd4;
  localparam cmd_t ST_LIMIT   = 3'd5;
  localparam cmd_t ST_UNKNOWN = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_STEER_NEUTRAL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_NEUTRAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THRESHOLD = 2'd2;

  localparam logic [7:0] CH_ECHO  = 8'h65;
  localparam logic [7:0] CH_MODE  = 8'h6d;
  localparam logic [7:0] CH_READ  = 8'h72;
  localparam logic [7:0] CH_WRITE = 8'h77;
  localparam logic [7:0] CH_LIMIT = 8'h4c;
  localparam logic [7:0] CH_INFO  = 8'h69;
  localparam logic [7:0] CH_USER  = 8'h75;
  localparam logic [7:0] CH_ANGLE = 8'h61;
  localparam logic [7:0] CH_PILOT = 8'h70;

  localparam val_t FULL_SCALE = 10'd1000;
  localparam val_t NEUTRAL_RST = 10'd500;
  localparam val_t THRESH_RST  = 10'd10;
  localparam sval_t PULSE_OFFSET = 17'sd1000;
  localparam sval_t PULSE_MIN    = -17'sd500;
  localparam sval_t ANGLE_BELOW  = 17'sd300;
  localparam sval_t PILOT_ABOVE  = 17'sd700;

  localparam logic [19:0] ROUND_HALF = 20'd500;
  localparam int unsigned RECIP_SHIFT = 24;
  localparam logic [17:0] RECIP_125 = 18'd134218;

  localparam val_t BIN_BOUND [0:14] = '{
    10'd0, 10'd36, 10'd108, 10'd179, 10'd250, 10'd322, 10'd393, 10'd465,
    10'd536, 10'd608, 10'd679, 10'd750, 10'd822, 10'd893, 10'd965
  };

  localparam val_t LEVEL_VALUE [0:15] = '{
    10'd0, 10'd71, 10'd143, 10'd214, 10'd286, 10'd357, 10'd429, 10'd500,
    10'd571, 10'd643, 10'd714, 10'd786, 10'd857, 10'd929, 10'd1000, 10'd1000
  };

  function automatic bin_t to_bin(input sval_t v);
    bin_t cnt;
    cnt = '0;
    for (int b = 1; b < 15; b++) begin
      if (v >= $signed({7'b0, BIN_BOUND[b]})) cnt = cnt + 4'd1;
    end
    return cnt;
  endfunction

  function automatic val_t unbin(input bin_t lvl);
    return LEVEL_VALUE[lvl];
  endfunction

  function automatic logic in_range(input sval_t v);
    return !v[SVAL_W-1] && (v <= $signed({7'b0, FULL_SCALE}));
  endfunction

endpackage

/* rtl/rc_pulse_override_controller_core.sv */
`timescale 1ns / 1ps
// rc pulse override controller
// input channel: one item per control loop pass, steering and throttle pulse
// widths in us plus an optional serial byte; in_valid / in_stall handshake
// output channel: held servo commands, drive mode, reply byte and a flag that
// says whether the serial byte was consumed; out_valid / out_stall handshake
// config channel: cfg_valid / cfg_ready, always ready; index 0 steer neutral,
// 1 throttle neutral, 2 change threshold; write only while idle
// path: a taken item goes through the input register, then the
// decode/multiply stage and the divide/saturate stage to the result register
// throughput: one item per cycle while the output is not stalled; the
// 10x10 throttle product and the reciprocal multiply for the divide by 1000 sit in separate stages
// stall: out_stall freezes the result register and backs up through the
// stages to in_stall in the same cycle, no item is lost
// reset: synchronous active-low rst_n clears valids, user mode, idle parser,
// holds at 500, limit 1000, neutrals 500, threshold 10
module rc_pulse_override_controller_core
  import rpoc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PULSE_W-1:0]   in_steer_pulse_us,
  input  logic [PULSE_W-1:0]   in_throttle_pulse_us,
  input  logic                 in_rx_valid,
  input  logic [7:0]           in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [VAL_W-1:0]     out_steering_cmd,
  output logic [VAL_W-1:0]     out_throttle_cmd,
  output logic [MODE_W-1:0]    out_drive_mode_out,
  output logic                 out_tx_valid,
  output logic [7:0]           out_tx_byte,
  output logic                 out_rx_taken,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data
);

  // handshake
  logic s0_valid_r, mid_valid_r, out_valid_r;
  logic out_free, mid_free, s0_free, a_fire, b_fire;

  assign out_free = !out_valid_r || !out_stall;
  assign mid_free = !mid_valid_r || out_free;
  assign s0_free  = !s0_valid_r || mid_free;
  assign a_fire   = s0_valid_r && mid_free;
  assign b_fire   = mid_valid_r && out_free;
  assign in_stall = !s0_free;
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

  // config registers
  val_t steer_neutral_r, throttle_neutral_r, change_threshold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steer_neutral_r    <= NEUTRAL_RST;
      throttle_neutral_r <= NEUTRAL_RST;
      change_threshold_r <= THRESH_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_STEER_NEUTRAL) steer_neutral_r <= cfg_data;
      if (cfg_index == REG_THROTTLE_NEUTRAL) throttle_neutral_r <= cfg_data;
      if (cfg_index == REG_CHANGE_THRESHOLD) change_threshold_r <= cfg_data;
    end
  end

  // input register
  logic [PULSE_W-1:0] s0_steer_us_r, s0_throttle_us_r;
  logic               s0_rx_valid_r;
  logic [7:0]         s0_rx_byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (s0_free) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s0_free) begin
      s0_steer_us_r    <= in_steer_pulse_us;
      s0_throttle_us_r <= in_throttle_pulse_us;
      s0_rx_valid_r    <= in_rx_valid;
      s0_rx_byte_r     <= in_rx_byte;
    end
  end

  // loop state
  sval_t last_steer_r, last_throttle_r;
  bin_t  steer_bin_r, throttle_bin_r;
  mode_t drive_mode_r;
  cmd_t  cmd_state_r;
  val_t  throttle_limit_r, steering_hold_r, throttle_hold_r;

  // stage a: decode, mode logic, parser, throttle product
  sval_t st_raw, th_raw, st_v, th_v;
  logic signed [SVAL_W:0] st_diff, th_diff;
  logic [SVAL_W:0] st_abs, th_abs;
  logic  st_moved, th_moved;
  mode_t mode_a, mode_nxt;
  val_t  steer_hold_nxt, thr_limit_nxt, lvl_hi, lvl_lo, thr_arg;
  bin_t  steer_bin_nxt, throttle_bin_nxt;
  cmd_t  cmd_nxt;
  logic  c1, c2, c3, thr_upd, tx_v, taken;
  logic [7:0] tx_b;
  logic signed [VAL_W:0] thr_d;
  logic  thr_sign;
  val_t  thr_mag;
  logic [2*VAL_W-1:0] thr_prod;

  always_comb begin
    st_raw = $signed({1'b0, s0_steer_us_r}) - PULSE_OFFSET;
    th_raw = $signed({1'b0, s0_throttle_us_r}) - PULSE_OFFSET;
    st_v = (st_raw < PULSE_MIN) ? $signed({7'b0, steer_neutral_r}) : st_raw;
    th_v = (th_raw < PULSE_MIN) ? $signed({7'b0, throttle_neutral_r}) : th_raw;
    st_diff = {last_steer_r[SVAL_W-1], last_steer_r} - {st_v[SVAL_W-1], st_v};
    th_diff = {last_throttle_r[SVAL_W-1], last_throttle_r} - {th_v[SVAL_W-1], th_v};
    st_abs = st_diff[SVAL_W] ? 18'(-st_diff) : 18'(st_diff);
    th_abs = th_diff[SVAL_W] ? 18'(-th_diff) : 18'(th_diff);
    st_moved = st_abs > {8'b0, change_threshold_r};
    th_moved = th_abs > {8'b0, change_threshold_r};

    mode_a = drive_mode_r;
    steer_hold_nxt = steering_hold_r;
    steer_bin_nxt = steer_bin_r;
    throttle_bin_nxt = throttle_bin_r;
    c1 = 1'b0;
    c2 = 1'b0;
    c3 = 1'b0;

    if (st_moved) begin
      steer_bin_nxt = to_bin(st_v);
      unique case (drive_mode_r)
        MODE_USER: begin
          if (in_range(st_v)) steer_hold_nxt = st_v[VAL_W-1:0];
        end
        MODE_PILOT: begin
          if (st_v < ANGLE_BELOW) mode_a = MODE_ANGLE;
          c1 = throttle_neutral_r <= FULL_SCALE;
        end
        MODE_ANGLE: begin
          if (st_v > PILOT_ABOVE) mode_a = MODE_PILOT;
        end
        default: begin
        end
      endcase
    end

    if (th_moved) begin
      throttle_bin_nxt = to_bin(th_v);
      c2 = (mode_a != MODE_PILOT) && in_range(th_v);
    end

    lvl_hi = unbin(s0_rx_byte_r[7:4]);
    lvl_lo = unbin(s0_rx_byte_r[3:0]);
    mode_nxt = mode_a;
    thr_limit_nxt = throttle_limit_r;
    cmd_nxt = cmd_state_r;
    tx_v = 1'b0;
    tx_b = 8'h00;
    taken = 1'b0;

    if (s0_rx_valid_r) begin
      cmd_nxt = ST_IDLE;
      unique case (cmd_state_r)
        ST_IDLE: begin
          taken = 1'b1;
          priority if (s0_rx_byte_r == CH_ECHO) cmd_nxt = ST_ECHO;
          else if (s0_rx_byte_r == CH_MODE) cmd_nxt = ST_MODE;
          else if (s0_rx_byte_r == CH_READ) cmd_nxt = ST_READ;
          else if (s0_rx_byte_r == CH_WRITE) cmd_nxt = ST_WRITE;
          else if (s0_rx_byte_r == CH_LIMIT) cmd_nxt = ST_LIMIT;
          else if (s0_rx_byte_r == CH_INFO) cmd_nxt = ST_IDLE;
          else cmd_nxt = ST_UNKNOWN;
        end
        ST_ECHO: begin
          taken = 1'b1;
        end
        ST_MODE: begin
          taken = 1'b1;
          priority if (s0_rx_byte_r == CH_USER) mode_nxt = MODE_USER;
          else if (s0_rx_byte_r == CH_ANGLE) mode_nxt = MODE_ANGLE;
          else if (s0_rx_byte_r == CH_PILOT) mode_nxt = MODE_PILOT;
          else mode_nxt = MODE_OTHER;
        end
        ST_READ: begin
          tx_v = 1'b1;
          tx_b = {steer_bin_nxt, throttle_bin_nxt};
        end
        ST_WRITE: begin
          taken = 1'b1;
          if (mode_a != MODE_USER) steer_hold_nxt = lvl_hi;
          c3 = mode_a == MODE_PILOT;
        end
        ST_LIMIT: begin
          taken = 1'b1;
          if (s0_rx_byte_r[7:4] == 4'h0) thr_limit_nxt = lvl_lo;
        end
        default: begin
        end
      endcase
    end

    // only the last throttle update of the item survives
    thr_upd = c1 || c2 || c3;
    priority if (c3) thr_arg = lvl_lo;
    else if (c2) thr_arg = th_v[VAL_W-1:0];
    else thr_arg = throttle_neutral_r;

    thr_d = $signed({1'b0, thr_arg}) - $signed({1'b0, throttle_neutral_r});
    thr_sign = thr_d[VAL_W];
    thr_mag = thr_sign ? VAL_W'(-thr_d) : VAL_W'(thr_d);
    thr_prod = thr_mag * throttle_limit_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_steer_r     <= '0;
      last_throttle_r  <= '0;
      steer_bin_r      <= '0;
      throttle_bin_r   <= '0;
      drive_mode_r     <= MODE_USER;
      cmd_state_r      <= ST_IDLE;
      throttle_limit_r <= FULL_SCALE;
      steering_hold_r  <= NEUTRAL_RST;
    end else if (a_fire) begin
      if (st_moved) last_steer_r <= st_v;
      if (th_moved) last_throttle_r <= th_v;
      steer_bin_r      <= steer_bin_nxt;
      throttle_bin_r   <= throttle_bin_nxt;
      drive_mode_r     <= mode_nxt;
      cmd_state_r      <= cmd_nxt;
      throttle_limit_r <= thr_limit_nxt;
      steering_hold_r  <= steer_hold_nxt;
    end
  end

  // mid register
  logic               mid_thr_upd_r, mid_thr_sign_r;
  logic [2*VAL_W-1:0] mid_thr_mag_r;
  val_t               mid_tn_r, mid_steer_r;
  mode_t              mid_mode_r;
  logic               mid_tx_valid_r, mid_taken_r;
  logic [7:0]         mid_tx_byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_valid_r <= 1'b0;
    end else if (mid_free) begin
      mid_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      mid_thr_upd_r  <= thr_upd;
      mid_thr_sign_r <= thr_sign;
      mid_thr_mag_r  <= thr_prod;
      mid_tn_r       <= throttle_neutral_r;
      mid_steer_r    <= steer_hold_nxt;
      mid_mode_r     <= mode_nxt;
      mid_tx_valid_r <= tx_v;
      mid_tx_byte_r  <= tx_b;
      mid_taken_r    <= taken;
    end
  end

  // stage b: round, divide by 1000, add to or subtract from neutral, saturate
  logic [2*VAL_W:0]   rnd_sum;
  logic [16:0]        div_in;
  logic [34:0]        div_prod;
  val_t               div_q;
  logic signed [11:0] thr_sum;
  val_t               thr_hold_nxt;

  always_comb begin
    rnd_sum  = {1'b0, mid_thr_mag_r} + {1'b0, ROUND_HALF};
    div_in   = rnd_sum[19:3];
    div_prod = div_in * RECIP_125;
    div_q    = div_prod[RECIP_SHIFT+VAL_W-1:RECIP_SHIFT];
    thr_sum  = mid_thr_sign_r ? $signed({2'b0, mid_tn_r}) - $signed({2'b0, div_q})
                              : $signed({2'b0, mid_tn_r}) + $signed({2'b0, div_q});
    priority if (thr_sum < 12'sd0) thr_hold_nxt = '0;
    else if (thr_sum > $signed({2'b0, FULL_SCALE})) thr_hold_nxt = FULL_SCALE;
    else thr_hold_nxt = thr_sum[VAL_W-1:0];
  end

  // result register
  val_t       out_steer_r;
  mode_t      out_mode_r;
  logic       out_tx_valid_r, out_taken_r;
  logic [7:0] out_tx_byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r     <= 1'b0;
      throttle_hold_r <= NEUTRAL_RST;
    end else begin
      if (out_free) out_valid_r <= mid_valid_r;
      if (b_fire && mid_thr_upd_r) throttle_hold_r <= thr_hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      out_steer_r    <= mid_steer_r;
      out_mode_r     <= mid_mode_r;
      out_tx_valid_r <= mid_tx_valid_r;
      out_tx_byte_r  <= mid_tx_byte_r;
      out_taken_r    <= mid_taken_r;
    end
  end

  assign out_steering_cmd   = out_steer_r;
  assign out_throttle_cmd   = throttle_hold_r;
  assign out_drive_mode_out = out_mode_r;
  assign out_tx_valid       = out_tx_valid_r;
  assign out_tx_byte        = out_tx_byte_r;
  assign out_rx_taken       = out_taken_r;

  // checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s0_valid_r && mid_valid_r && out_valid_r && out_stall))
    else $error("input stalled while a stage is free");

  a_mode_moves_on_item: assert property (@(posedge clk) disable iff (!rst_n)
    !a_fire |=> $stable(drive_mode_r))
    else $error("drive mode changed without an item");

  a_hold_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (throttle_hold_r <= FULL_SCALE) && (steering_hold_r <= FULL_SCALE))
    else $error("servo hold out of range");

  a_reply_not_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tx_valid_r) |-> !out_taken_r)
    else $error("reply item also consumed the byte");

endmodule
